// File: design/nlpe_pkg.sv
package nlpe_pkg;

  // item opcodes
  localparam logic OP_BEGIN    = 1'b0;
  localparam logic OP_NEIGHBOR = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd2;

  localparam logic [15:0] CAPACITY_RESET = 16'd237;

  // wire-format bytes
  localparam logic [7:0] TAG_HDR_F1   = 8'h08;  // field 1, varint
  localparam logic [7:0] TAG_HDR_F2   = 8'h10;  // field 2, varint
  localparam logic [7:0] TAG_HDR_F3   = 8'h18;  // field 3, varint
  localparam logic [7:0] TAG_NEIGHBOR = 8'h22;  // field 4, length-delimited
  localparam logic [7:0] TAG_NODE     = 8'h08;  // submessage field 1, varint
  localparam logic [7:0] TAG_SNR      = 8'h15;  // submessage field 2, fixed32
  localparam logic       VARINT_CONT  = 1'b1;   // continuation bit of a group

  // x / 13 for 16-bit x as (x * 80660) >> 20, exact over the whole range
  localparam logic [16:0] RECIP_13    = 17'd80660;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned ROOM_W      = 13;

  // one queued item, fully classified
  typedef struct packed {
    logic              op;
    logic [31:0]       val_a;    // own node or neighbor node
    logic [31:0]       val_b;    // broadcast interval or SNR pattern
    logic [2:0]        vlen_a;   // varint length of val_a
    logic [2:0]        vlen_b;   // varint length of val_b
    logic [4:0]        len;      // bytes to emit, 0 = one empty word
    logic [ROOM_W-1:0] room;
    logic [15:0]       base;     // message length before this item
    logic              ovf;
    logic              last;
  } desc_t;

  // varint byte count of a 32-bit value (1..5)
  function automatic logic [2:0] varint_len(input logic [31:0] v);
    logic [2:0] n;
    if (v[31:28] != 4'd0) begin
      n = 3'd5;
    end else if (v[27:21] != 7'd0) begin
      n = 3'd4;
    end else if (v[20:14] != 7'd0) begin
      n = 3'd3;
    end else if (v[13:7] != 7'd0) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

endpackage

// File: design/nlpe_front.sv
module nlpe_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               op,
  input  logic [31:0]        neighbor_node,
  input  logic [31:0]        neighbor_snr_bits,
  input  logic               last_entry,
  input  logic [31:0]        own_node_number,
  input  logic [31:0]        broadcast_interval,
  input  logic [15:0]        capacity_bytes,
  output nlpe_pkg::desc_t    desc
);

  logic [15:0] bytes_emitted, bytes_emitted_next;
  logic        overflow_seen, overflow_seen_next;

  logic [2:0]  vl_own, vl_bi, vl_node;
  logic [3:0]  fld_own, fld_bi, nb_len;
  logic [4:0]  hdr_len;
  logic        hdr_ovf, hdr_room_ok, nb_ovf;
  logic [15:0] room_diff;
  logic [32:0] room_prod;

  assign vl_own  = nblen_guard(own_node_number);
  assign vl_bi   = nblen_guard(broadcast_interval);
  assign vl_node = nblen_guard(neighbor_node);

  function automatic logic [2:0] nblen_guard(input logic [31:0] v);
    return nlpe_pkg::varint_len(v);
  endfunction

  // header: tag + varint per nonzero field, own node written twice
  assign fld_own = (own_node_number != 32'd0) ? {1'b0, vl_own} + 4'd1 : 4'd0;
  assign fld_bi  = (broadcast_interval != 32'd0) ? {1'b0, vl_bi} + 4'd1 : 4'd0;
  assign hdr_len = {fld_own, 1'b0} + {1'b0, fld_bi};

  assign hdr_ovf     = {11'd0, hdr_len} > capacity_bytes;
  assign hdr_room_ok = {11'd0, hdr_len} < capacity_bytes;
  assign room_diff   = capacity_bytes - {11'd0, hdr_len};
  assign room_prod   = 33'(room_diff) * 33'(nlpe_pkg::RECIP_13);

  // neighbor entry: 0x22, length, optional node field, optional SNR field
  assign nb_len = ((neighbor_node != 32'd0) ? {1'b0, vl_node} + 4'd1 : 4'd0)
                + ((neighbor_snr_bits != 32'd0) ? 4'd5 : 4'd0) + 4'd2;
  assign nb_ovf = ({1'b0, bytes_emitted} + 17'(nb_len)) > {1'b0, capacity_bytes};

  always_comb begin
    desc.op   = op;
    desc.last = last_entry;
    desc.room = '0;
    bytes_emitted_next = bytes_emitted;
    overflow_seen_next = overflow_seen;
    if (op == nlpe_pkg::OP_BEGIN) begin
      desc.val_a  = own_node_number;
      desc.val_b  = broadcast_interval;
      desc.vlen_a = vl_own;
      desc.vlen_b = vl_bi;
      desc.len    = hdr_ovf ? 5'd0 : hdr_len;
      desc.base   = 16'd0;
      desc.ovf    = hdr_ovf;
      if (hdr_room_ok) begin
        desc.room = room_prod[nlpe_pkg::RECIP_SHIFT +: nlpe_pkg::ROOM_W];
      end
      bytes_emitted_next = hdr_ovf ? 16'd0 : {11'd0, hdr_len};
      overflow_seen_next = hdr_ovf;
    end else begin
      desc.val_a  = neighbor_node;
      desc.val_b  = neighbor_snr_bits;
      desc.vlen_a = vl_node;
      desc.vlen_b = 3'd0;
      desc.base   = bytes_emitted;
      if (overflow_seen) begin
        desc.len = 5'd0;
        desc.ovf = 1'b1;
      end else begin
        desc.len = nb_ovf ? 5'd0 : {1'b0, nb_len};
        desc.ovf = nb_ovf;
        overflow_seen_next = nb_ovf;
        if (!nb_ovf) begin
          bytes_emitted_next = bytes_emitted + {12'd0, nb_len};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_emitted <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      bytes_emitted <= bytes_emitted_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

// File: design/nlpe_queue.sv
module nlpe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  nlpe_pkg::desc_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output nlpe_pkg::desc_t rd_data,
  output logic            q_empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  nlpe_pkg::desc_t    slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/nlpe_back.sv
module nlpe_back (
  input  logic                          clk,
  input  logic                          rst,
  input  nlpe_pkg::desc_t               d,
  input  logic                          q_empty,
  output logic                          rd_en,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte,
  output logic                          byte_valid,
  output logic                          run_last,
  output logic                          overflow,
  output logic                          message_done,
  output logic [15:0]                   message_length,
  output logic [nlpe_pkg::ROOM_W-1:0]   neighbor_room
);

  logic [4:0]  k;
  logic        out_valid;
  logic        advance, is_last, valid;

  logic [4:0]  fld_a, off3, kk, j;
  logic [7:0]  tag, cur_byte, vbyte, rbyte;
  logic [31:0] v;
  logic [2:0]  vl, idx;
  logic        raw, fixed_byte;
  logic [7:0]  fixed_val;
  logic [6:0]  grp;

  assign valid   = (d.len != 5'd0);
  assign is_last = !valid || (k == d.len - 5'd1);
  assign advance = !q_empty && (!out_valid || pop);
  assign rd_en   = advance && is_last;
  assign empty   = !out_valid;

  assign fld_a = (d.val_a != 32'd0) ? {2'b0, d.vlen_a} + 5'd1 : 5'd0;
  assign off3  = {fld_a[3:0], 1'b0};
  assign kk    = k - 5'd2;

  // locate byte k: which field, position j inside it (0 = tag)
  always_comb begin
    fixed_byte = 1'b0;
    fixed_val  = 8'd0;
    raw        = 1'b0;
    v          = d.val_a;
    vl         = d.vlen_a;
    tag        = nlpe_pkg::TAG_HDR_F1;
    j          = k;
    if (d.op == nlpe_pkg::OP_BEGIN) begin
      if (k < fld_a) begin
        j   = k;
      end else if (k < off3) begin
        j   = k - fld_a;
        tag = nlpe_pkg::TAG_HDR_F2;
      end else begin
        j   = k - off3;
        tag = nlpe_pkg::TAG_HDR_F3;
        v   = d.val_b;
        vl  = d.vlen_b;
      end
    end else begin
      if (k == 5'd0) begin
        fixed_byte = 1'b1;
        fixed_val  = nlpe_pkg::TAG_NEIGHBOR;
      end else if (k == 5'd1) begin
        fixed_byte = 1'b1;
        fixed_val  = 8'(d.len - 5'd2);
      end else if (kk < fld_a) begin
        j   = kk;
        tag = nlpe_pkg::TAG_NODE;
      end else begin
        j   = kk - fld_a;
        tag = nlpe_pkg::TAG_SNR;
        v   = d.val_b;
        raw = 1'b1;
      end
    end
  end

  assign idx = 3'(j - 5'd1);

  always_comb begin
    case (idx)
      3'd0:    grp = v[6:0];
      3'd1:    grp = v[13:7];
      3'd2:    grp = v[20:14];
      3'd3:    grp = v[27:21];
      3'd4:    grp = {3'd0, v[31:28]};
      default: grp = 7'd0;
    endcase
    case (idx)
      3'd0:    rbyte = v[7:0];
      3'd1:    rbyte = v[15:8];
      3'd2:    rbyte = v[23:16];
      3'd3:    rbyte = v[31:24];
      default: rbyte = 8'd0;
    endcase
  end

  assign vbyte = {(({1'b0, idx} + 4'd1) < {1'b0, vl}) ? nlpe_pkg::VARINT_CONT : 1'b0, grp};

  always_comb begin
    if (!valid) begin
      cur_byte = 8'd0;
    end else if (fixed_byte) begin
      cur_byte = fixed_val;
    end else if (j == 5'd0) begin
      cur_byte = tag;
    end else if (raw) begin
      cur_byte = rbyte;
    end else begin
      cur_byte = vbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        k         <= is_last ? 5'd0 : k + 5'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte       <= cur_byte;
      byte_valid     <= valid;
      run_last       <= is_last;
      overflow       <= d.ovf;
      message_done   <= is_last && d.last;
      message_length <= valid ? d.base + {11'd0, k} + 16'd1 : d.base;
      neighbor_room  <= d.room;
    end
  end

  a_empty_word_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (out_byte == 8'd0 && run_last))
    else $error("empty word carries a byte or is not final");

  a_done_on_final: assert property (@(posedge clk) disable iff (rst)
    (!empty && message_done) |-> run_last)
    else $error("message_done off the final word");

  a_length_steps: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && byte_valid && !run_last) |=>
      (!empty && byte_valid && message_length == $past(message_length) + 16'd1))
    else $error("byte run broken or length not stepping");

endmodule

// File: design/neighbor_list_protobuf_encoder.sv
// Neighbor-report message encoder, protobuf wire format, one byte per word.
//
// Input channel (push/full): one item per word. op 0 starts a message and
// emits the header (own node as fields 1 and 2, broadcast interval as field
// 3, zero fields skipped) plus the neighbor_room estimate; op 1 appends one
// field-4 neighbor entry (2 to 13 bytes). An item that emits nothing, or does
// not fit in capacity_bytes, yields one word with byte_valid low.
// Result channel (empty/pop): one word per byte, run_last on the final word
// of each item, message_done on the final word of a last_entry item.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 own node,
// 1 broadcast interval, 2 capacity; write only while the block is idle.
// An accepted item is written into the queue, then its first word into the
// output register. Throughput: one word per cycle while the receiver pops; an
// item takes max(bytes, 1) words, up to 13 for a neighbor and 18 for a header;
// the front classifies one item per cycle into a QUEUE_DEPTH queue unless full.
// Reset clears queue, output word, message state and config (capacity 237).
// A stalled receiver holds the output word; the queue keeps taking items
// until it fills, then full rises.
module neighbor_list_protobuf_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                push,
  output logic                                full,
  input  logic                                op,
  input  logic [31:0]                         neighbor_node,
  input  logic [31:0]                         neighbor_snr_bits,
  input  logic                                last_entry,
  // result words
  output logic                                empty,
  input  logic                                pop,
  output logic [7:0]                          out_byte,
  output logic                                byte_valid,
  output logic                                run_last,
  output logic                                overflow,
  output logic                                message_done,
  output logic [15:0]                         message_length,
  output logic [nlpe_pkg::ROOM_W-1:0]         neighbor_room,
  // config writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nlpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);

  logic [31:0]     own_node_number;
  logic [31:0]     broadcast_interval;
  logic [15:0]     capacity_bytes;

  logic            accept;
  nlpe_pkg::desc_t front_desc, head_desc;
  logic            q_empty, rd_en;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      own_node_number    <= '0;
      broadcast_interval <= '0;
      capacity_bytes     <= nlpe_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nlpe_pkg::CFG_OWN_NODE: own_node_number    <= cfg_data;
        nlpe_pkg::CFG_INTERVAL: broadcast_interval <= cfg_data;
        nlpe_pkg::CFG_CAPACITY: capacity_bytes     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // front: length, fit check and message state, one item per cycle unless the queue is full
  nlpe_front u_front (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .op                 (op),
    .neighbor_node      (neighbor_node),
    .neighbor_snr_bits  (neighbor_snr_bits),
    .last_entry         (last_entry),
    .own_node_number    (own_node_number),
    .broadcast_interval (broadcast_interval),
    .capacity_bytes     (capacity_bytes),
    .desc               (front_desc)
  );

  // decoupling queue between classification and byte emission
  nlpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_desc),
    .full    (full),
    .rd_en   (rd_en),
    .rd_data (head_desc),
    .q_empty (q_empty)
  );

  // back: byte sequencer with registered output word
  nlpe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .d              (head_desc),
    .q_empty        (q_empty),
    .rd_en          (rd_en),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .run_last       (run_last),
    .overflow       (overflow),
    .message_done   (message_done),
    .message_length (message_length),
    .neighbor_room  (neighbor_room)
  );

endmodule
